// ===== rtl/shbi_pkg.sv =====
`timescale 1ns / 1ps

package shbi_pkg;

   localparam int HASH_W         = 64;
   localparam int HALF_W         = 32;
   localparam int BYTE_W         = 8;
   localparam int ALG_W          = 2;
   localparam int MAX_TABLE_SIZE = 65536;
   localparam int SIZE_W         = $clog2(MAX_TABLE_SIZE + 1);
   localparam int REM_W          = $clog2(MAX_TABLE_SIZE);
   localparam int TRIAL_W        = SIZE_W + 1;
   localparam int INDEX_W        = 16;
   localparam int BITS_PER_STEP  = 4;
   localparam int DIV_STEPS      = HASH_W / BITS_PER_STEP;
   localparam int STEP_W         = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [ALG_W-1:0] ALG_SHIFT_XOR = 2'd0;
   localparam logic [ALG_W-1:0] ALG_DJB2      = 2'd1;
   localparam logic [ALG_W-1:0] ALG_SDBM      = 2'd2;
   localparam logic [ALG_W-1:0] ALG_FNV1A     = 2'd3;
   localparam logic [ALG_W-1:0] ALG_RESET     = ALG_DJB2;

   localparam logic REG_ALGORITHM_SELECT = 1'b0;
   localparam logic REG_TABLE_SIZE       = 1'b1;

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(256);

   localparam logic [HASH_W-1:0] SEED_DJB2  = 64'd5381;
   localparam logic [HALF_W-1:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [HALF_W-1:0] FNV_PRIME  = 32'd16777619;

   typedef struct packed {
      logic [ALG_W-1:0]  alg;
      logic [SIZE_W-1:0] size;
   } cfg_type;

   typedef struct packed {
      logic             reseed;
      logic [ALG_W-1:0] alg;
   } reseed_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [SIZE_W-1:0] size;
   } key_entry_type;

   function automatic logic [HASH_W-1:0] seed_of(input logic [ALG_W-1:0] alg);
      logic [HASH_W-1:0] s;
      case (alg)
         ALG_DJB2: s = SEED_DJB2;
         ALG_FNV1A: s = HASH_W'(FNV_OFFSET);
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [HASH_W-1:0] mix_byte(input logic [ALG_W-1:0] alg,
                                                   input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] c;
      logic [HALF_W-1:0] h32;
      logic [HALF_W-1:0] c32;
      logic [HALF_W-1:0] t32;
      logic [HASH_W-1:0] r;
      c   = {{(HASH_W - BYTE_W){b[BYTE_W-1]}}, b};
      h32 = h[HALF_W-1:0];
      c32 = c[HALF_W-1:0];
      case (alg)
         ALG_SHIFT_XOR: begin
            t32 = (h32 << 5) + (h32 >> 2) + c32;
            r   = HASH_W'(h32 ^ t32);
         end
         ALG_DJB2: begin
            t32 = '0;
            r   = (h << 5) + h + c;
         end
         ALG_SDBM: begin
            t32 = '0;
            r   = c + (h << 6) + (h << 16) - h;
         end
         default: begin
            t32 = (h32 ^ c32) * FNV_PRIME;
            r   = HASH_W'(t32);
         end
      endcase
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] s;
      if (size == '0) begin
         s = SIZE_W'(1);
      end else if (size > SIZE_W'(MAX_TABLE_SIZE)) begin
         s = SIZE_W'(MAX_TABLE_SIZE);
      end else begin
         s = size;
      end
      return s;
   endfunction

   function automatic logic [HASH_W-1:0] final_hash(input logic [ALG_W-1:0] alg,
                                                     input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] r;
      if (alg == ALG_SHIFT_XOR || alg == ALG_FNV1A) begin
         r = HASH_W'(h[HALF_W-1:0]);
      end else begin
         r = h;
      end
      return r;
   endfunction

endpackage

// ===== rtl/shbi_front.sv =====
`timescale 1ns / 1ps

module shbi_front import shbi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_key_byte,
   input  cfg_type             cfg,
   input  reseed_type          reseed,
   input  logic                queue_full,
   output logic                push_valid,
   output key_entry_type       push_entry
);

   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;
   logic              accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      hash_in         = hash_ff;
      push_valid      = 1'b0;
      push_entry.hash = final_hash(cfg.alg, hash_ff);
      push_entry.size = effective_size(cfg.size);
      if (reseed.reseed) begin
         hash_in = seed_of(reseed.alg);
      end else if (accept) begin
         if (req_key_byte != '0) begin
            hash_in = mix_byte(cfg.alg, hash_ff, req_key_byte);
         end else begin
            // key end: hand the finished hash to the back end and reseed
            push_valid = 1'b1;
            hash_in    = seed_of(cfg.alg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= seed_of(ALG_RESET);
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

// ===== rtl/shbi_queue.sv =====
`timescale 1ns / 1ps

module shbi_queue import shbi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  key_entry_type push_entry,
   input  logic          pop,
   output key_entry_type head_entry,
   output logic          empty,
   output logic          full
);

   key_entry_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff;
   logic [QPTR_W-1:0] head_in;
   logic [QPTR_W-1:0] tail_ff;
   logic [QPTR_W-1:0] tail_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_entry = entries_ff[head_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   always_comb begin
      head_in  = do_pop ? QPTR_W'(head_ff + 1'b1) : head_ff;
      tail_in  = do_push ? QPTR_W'(tail_ff + 1'b1) : tail_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[tail_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/shbi_divider.sv =====
`timescale 1ns / 1ps

module shbi_divider import shbi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  key_entry_type       head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [INDEX_W-1:0]  rsp_bucket_index
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   logic [HASH_W-1:0]  dividend_ff;
   logic [HASH_W-1:0]  dividend_in;
   logic [SIZE_W-1:0]  divisor_ff;
   logic [SIZE_W-1:0]  divisor_in;
   logic [REM_W-1:0]   rem_ff;
   logic [REM_W-1:0]   rem_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [INDEX_W-1:0] rsp_index_in;
   logic [REM_W-1:0]   rem_step;
   logic [HASH_W-1:0]  dividend_step;
   logic [TRIAL_W-1:0] trial;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = rsp_index_ff;

   // restoring division, several quotient bits per cycle
   always_comb begin
      rem_step      = rem_ff;
      dividend_step = dividend_ff;
      trial         = '0;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         trial         = TRIAL_W'({rem_step, dividend_step[HASH_W-1]});
         dividend_step = dividend_step << 1;
         if (trial >= TRIAL_W'(divisor_ff)) begin
            rem_step = REM_W'(trial - TRIAL_W'(divisor_ff));
         end else begin
            rem_step = REM_W'(trial);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      dividend_in  = dividend_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop         = 1'b1;
               dividend_in = head_entry.hash;
               divisor_in  = head_entry.size;
               rem_in      = '0;
               step_in     = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            dividend_in = dividend_step;
            rem_in      = rem_step;
            step_in     = STEP_W'(step_ff + 1'b1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = INDEX_W'(rem_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff  <= dividend_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      rsp_index_ff <= rsp_index_in;
   end

endmodule

// ===== rtl/string_hash_bucket_index.sv =====
`timescale 1ns / 1ps

// Hashes a key streamed one byte per transfer and returns its bucket index. Bytes are accepted
// one per cycle while req_ready is high and mixed into the running hash (shift-xor, djb2, sdbm
// or FNV-1a, chosen by algorithm_select); a zero byte ends the key, produces no hash step, and
// queues the final hash together with the table size for the back end, then reseeds. The back
// end computes the hash modulo the table size in a divider that retires 4 bits per cycle; each
// key is loaded, runs 16 divide steps and is registered before its result transfer is offered.
// A four-entry queue separates the two halves: bytes keep flowing until four finished keys
// wait, and req_ready drops only then. Writing algorithm_select reseeds the hash and drops a
// partial key; table_size applies at the next key end, with zero read as one and values above
// 65536 clamped. Registers sit at byte address 0 (algorithm_select) and 4 (table_size).

module string_hash_bucket_index import shbi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_key_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [INDEX_W-1:0]    rsp_bucket_index,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [ALG_W-1:0]  alg_ff;
   logic [ALG_W-1:0]  alg_in;
   logic [SIZE_W-1:0] table_size_ff;
   logic [SIZE_W-1:0] table_size_in;
   logic              csr_write;
   logic              csr_index;
   cfg_type           cfg;
   reseed_type        reseed;
   logic              push_valid;
   key_entry_type     push_entry;
   key_entry_type     head_entry;
   logic              queue_empty;
   logic              queue_full;
   logic              pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[2];

   always_comb begin
      alg_in        = alg_ff;
      table_size_in = table_size_ff;
      reseed.reseed = 1'b0;
      reseed.alg    = pwdata[ALG_W-1:0];
      if (csr_write) begin
         case (csr_index)
            REG_ALGORITHM_SELECT: begin
               alg_in        = pwdata[ALG_W-1:0];
               reseed.reseed = 1'b1;
            end
            REG_TABLE_SIZE: begin
               table_size_in = pwdata[SIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ALGORITHM_SELECT: prdata = CSR_DATA_W'(alg_ff);
         REG_TABLE_SIZE: prdata = CSR_DATA_W'(table_size_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alg_ff        <= ALG_RESET;
         table_size_ff <= TABLE_SIZE_RESET;
      end else begin
         alg_ff        <= alg_in;
         table_size_ff <= table_size_in;
      end
   end

   assign cfg.alg  = alg_ff;
   assign cfg.size = table_size_ff;

   shbi_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_key_byte (req_key_byte),
      .cfg          (cfg),
      .reseed       (reseed),
      .queue_full   (queue_full),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   shbi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   shbi_divider u_divider (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule

// ===== rtl/shbi_checker.sv =====
`timescale 1ns / 1ps

module shbi_checker import shbi_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [INDEX_W-1:0]    rsp_bucket_index,
   input logic                  psel,
   input logic                  penable,
   input logic                  pready
);

   // stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bucket_index))
      else $error("result changed while stalled");

   // no result is pending out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // queue is empty after reset, so bytes are taken at once
   a_req_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

   // register port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      psel && penable |-> pready)
      else $error("register access stalled");

endmodule

bind string_hash_bucket_index shbi_checker u_checker (.*);
